// ----- src/text_console_cursor_scroll_defines.svh -----
// assertion macros for the text console
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// same-cycle implication
`define TCCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tccs_pkg.sv -----
package tccs_pkg;

   localparam int COLUMNS     = 32;
   localparam int ROWS        = 24;
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int DEPTH       = COLUMNS * ROWS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

   localparam logic [7:0] BLANK_CODE = 8'd32;
   localparam logic [7:0] CODE_CR    = 8'd13;
   localparam logic [7:0] CODE_LF    = 8'd10;
   localparam logic [7:0] CODE_NONE  = 8'd0;

   localparam logic [2:0] KIND_PUT   = 3'd0;
   localparam logic [2:0] KIND_SET   = 3'd1;
   localparam logic [2:0] KIND_BACK  = 3'd2;
   localparam logic [2:0] KIND_CLEAR = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_SET,
      OP_BACK,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        char_code;
      logic signed [7:0] target_col;
      logic signed [7:0] target_row;
      logic [4:0]        read_col;
      logic [4:0]        read_row;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [7:0]       cell_char;
      logic             did_scroll;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       char_code;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   function automatic logic [ADDR_W-1:0] phys_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] top);
      logic [ROW_W:0] pr;
      pr = {1'b0, row} + {1'b0, top};
      if (pr >= (ROW_W + 1)'(ROWS)) begin
         pr = pr - (ROW_W + 1)'(ROWS);
      end
      return ADDR_W'(ADDR_W'(pr) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
   endfunction

endpackage

// ----- src/text_console_cursor_scroll.sv -----
// results: put, set cursor, step back, clear and unused kinds strobe once the command has passed the queue
// register and the result register; a read also passes ST_READ (registered read of the screen memory port)
// throughput: one transaction per cycle while busy is low, a read also holds the back end in ST_READ; a scroll
// holds the back end in ST_SWEEP blanking a row, a clear blanking the whole screen, one memory write per cycle
// reset: after synchronous reset a clearing pass over the whole screen runs with busy high
// the receiver cannot stall: each result shows for one cycle with rsp_strobe
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tccs_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tccs_pkg::rsp_type rsp_item
);
   import tccs_pkg::*;

   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   back_status_type  back_status;

   tccs_front u_front (
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .q_status    (q_status),
      .back_status (back_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tccs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   tccs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .back_status (back_status)
   );

   `TCCS_ASSERT_NEXT(a_push_lands, start && !busy, !q_status.empty, "accepted transaction lost")
   `TCCS_ASSERT_NOW(a_scroll_pos, rsp_strobe && rsp_item.did_scroll, (rsp_item.cursor_col == '0) && (rsp_item.cursor_row == ROW_LAST), "scroll without cursor at last row start")
   `TCCS_ASSERT_NOW(a_row_range, rsp_strobe, rsp_item.cursor_row <= ROW_LAST, "cursor row off screen")
   `TCCS_ASSERT_NOW(a_init_quiet, back_status.init_busy, busy && !rsp_strobe, "activity during clearing pass")

endmodule

// ----- src/tccs_front.sv -----
module tccs_front (
   input  logic                      start,
   output logic                      busy,
   input  tccs_pkg::req_type         req_item,
   input  tccs_pkg::queue_status_type q_status,
   input  tccs_pkg::back_status_type back_status,
   output logic                      push,
   output tccs_pkg::cmd_type         push_cmd
);
   import tccs_pkg::*;

   logic [COL_W-1:0] set_col;
   logic [ROW_W-1:0] set_row;
   logic [COL_W-1:0] rd_col;
   logic [ROW_W-1:0] rd_row;

   assign busy = q_status.full || back_status.init_busy;
   assign push = start && !busy;

   always_comb begin
      if (req_item.target_col[7]) begin
         set_col = '0;
      end else if (req_item.target_col[6:0] > 7'(COLUMNS - 1)) begin
         set_col = COL_LAST;
      end else begin
         set_col = req_item.target_col[COL_W-1:0];
      end
      if (req_item.target_row[7]) begin
         set_row = '0;
      end else if (req_item.target_row[6:0] > 7'(ROWS - 1)) begin
         set_row = ROW_LAST;
      end else begin
         set_row = req_item.target_row[ROW_W-1:0];
      end
      rd_col = (req_item.read_col > 5'(COLUMNS - 1)) ? COL_LAST : req_item.read_col[COL_W-1:0];
      rd_row = (req_item.read_row > 5'(ROWS - 1)) ? ROW_LAST : req_item.read_row[ROW_W-1:0];
   end

   always_comb begin
      push_cmd.char_code = req_item.char_code;
      push_cmd.col       = set_col;
      push_cmd.row       = set_row;
      unique case (req_item.kind)
         KIND_PUT:   push_cmd.op = OP_PUT;
         KIND_SET:   push_cmd.op = OP_SET;
         KIND_BACK:  push_cmd.op = OP_BACK;
         KIND_CLEAR: push_cmd.op = OP_CLEAR;
         KIND_READ: begin
            push_cmd.op  = OP_READ;
            push_cmd.col = rd_col;
            push_cmd.row = rd_row;
         end
         default:    push_cmd.op = OP_NOP;
      endcase
   end

endmodule

// ----- src/tccs_queue.sv -----
module tccs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tccs_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output tccs_pkg::cmd_type          head_cmd,
   output tccs_pkg::queue_status_type q_status
);
   import tccs_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/tccs_back.sv -----
module tccs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tccs_pkg::cmd_type         head_cmd,
   input  tccs_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_strobe,
   output tccs_pkg::rsp_type         rsp_item,
   output tccs_pkg::back_status_type back_status
);
   import tccs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   logic [7:0] screen_mem [DEPTH];
   logic [7:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_last_ff, sweep_last_in;
   logic              init_ff, init_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic [COL_W:0]    put_col;
   logic [ROW_W:0]    put_row;
   logic              put_store;
   logic              put_scroll;
   logic [ADDR_W-1:0] old_top_base;

   assign pop                   = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_strobe            = strobe_ff;
   assign rsp_item              = rsp_ff;
   assign back_status.init_busy = init_ff;
   assign old_top_base          = ADDR_W'(ADDR_W'(top_ff) * ADDR_W'(COLUMNS));

   // cursor motion of a put
   always_comb begin
      put_col    = {1'b0, col_ff};
      put_row    = {1'b0, row_ff};
      put_store  = 1'b0;
      put_scroll = 1'b0;
      if (head_cmd.char_code != CODE_NONE) begin
         if (head_cmd.char_code == CODE_CR) begin
            put_col = '0;
         end else if (head_cmd.char_code == CODE_LF) begin
            put_row = put_row + 1'b1;
         end else begin
            put_store = 1'b1;
            put_col   = put_col + 1'b1;
         end
         if (put_col > {1'b0, COL_LAST}) begin
            put_col = '0;
            put_row = put_row + 1'b1;
         end
         if (put_row > {1'b0, ROW_LAST}) begin
            put_row    = {1'b0, ROW_LAST};
            put_col    = '0;
            put_scroll = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      init_in       = init_ff;
      strobe_in     = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = phys_addr(col_ff, row_ff, top_ff);
      mem_wdata     = head_cmd.char_code;
      mem_re        = 1'b0;
      mem_raddr     = phys_addr(head_cmd.col, head_cmd.row, top_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head_cmd.op)
                  OP_PUT: begin
                     mem_we = put_store;
                     col_in = put_col[COL_W-1:0];
                     row_in = put_row[ROW_W-1:0];
                     if (put_scroll) begin
                        top_in        = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
                        sweep_addr_in = old_top_base;
                        sweep_last_in = old_top_base + ADDR_W'(COLUMNS - 1);
                        state_in      = ST_SWEEP;
                     end
                  end
                  OP_SET: begin
                     col_in = head_cmd.col;
                     row_in = head_cmd.row;
                  end
                  OP_BACK: begin
                     if (col_ff == '0) begin
                        if (row_ff != '0) begin
                           col_in = COL_LAST;
                           row_in = row_ff - 1'b1;
                        end
                     end else begin
                        col_in = col_ff - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     top_in        = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = ADDR_W'(DEPTH - 1);
                     state_in      = ST_SWEEP;
                  end
                  OP_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
               if (head_cmd.op != OP_READ) begin
                  strobe_in         = 1'b1;
                  rsp_in.cursor_col = col_in;
                  rsp_in.cursor_row = row_in;
                  rsp_in.cell_char  = '0;
                  rsp_in.did_scroll = (head_cmd.op == OP_PUT) && put_scroll;
               end
            end
         end
         ST_READ: begin
            strobe_in         = 1'b1;
            rsp_in.cursor_col = col_ff;
            rsp_in.cursor_row = row_ff;
            rsp_in.cell_char  = rd_data_ff;
            rsp_in.did_scroll = 1'b0;
            state_in          = ST_IDLE;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = BLANK_CODE;
            if (sweep_addr_ff == sweep_last_ff) begin
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         col_ff        <= '0;
         row_ff        <= '0;
         top_ff        <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= ADDR_W'(DEPTH - 1);
         init_ff       <= 1'b1;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         init_ff       <= init_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

endmodule

// ----- bench/tb.sv -----
module tb;
   import tccs_pkg::*;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_FIRST   = 500;
   localparam int CALM_LAST    = 800;
   localparam int MAX_GAP      = 6;
   localparam int MAX_ERRORS_SHOWN = 50;
   localparam int CYCLE_LIMIT  = 3 * (RANDOM_ITEMS + 100) * (DEPTH + MAX_GAP + 4) + 4 * DEPTH;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic [7:0] screen_cells [DEPTH];
   int         cur_col;
   int         cur_row;
   int         top_line;
   rsp_type    pending_rsp [$];
   int         error_count;
   int         sent_count;
   int         checked_count;
   int         scroll_count;
   int         read_count;
   int         clear_count;
   int         cycle_count;
   bit         no_gaps;

   text_console_cursor_scroll DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_ERRORS_SHOWN) begin
         $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   function automatic int cell_index(input int col, input int row);
      return ((row + top_line) % ROWS) * COLUMNS + col;
   endfunction

   function automatic void blank_screen();
      foreach (screen_cells[i]) screen_cells[i] = BLANK_CODE;
      cur_col  = 0;
      cur_row  = 0;
      top_line = 0;
   endfunction

   function automatic int clamp_target(input logic signed [7:0] v, input int limit);
      if (v < 0) return 0;
      if (int'(v) > limit - 1) return limit - 1;
      return int'(v);
   endfunction

   function automatic rsp_type console_step(input req_type item);
      rsp_type want;
      int      rc;
      int      rr;
      want = '0;
      case (item.kind)
         KIND_PUT: begin
            if (item.char_code != CODE_NONE) begin
               if (item.char_code == CODE_CR) begin
                  cur_col = 0;
               end else if (item.char_code == CODE_LF) begin
                  cur_row++;
               end else begin
                  screen_cells[cell_index(cur_col, cur_row)] = item.char_code;
                  cur_col++;
               end
               if (cur_col > COLUMNS - 1) begin
                  cur_col = 0;
                  cur_row++;
               end
               if (cur_row > ROWS - 1) begin
                  cur_row  = ROWS - 1;
                  cur_col  = 0;
                  top_line = (top_line + 1) % ROWS;
                  for (int c = 0; c < COLUMNS; c++) begin
                     screen_cells[cell_index(c, ROWS - 1)] = BLANK_CODE;
                  end
                  want.did_scroll = 1'b1;
               end
            end
         end
         KIND_SET: begin
            cur_col = clamp_target(item.target_col, COLUMNS);
            cur_row = clamp_target(item.target_row, ROWS);
         end
         KIND_BACK: begin
            if (cur_col == 0) begin
               if (cur_row != 0) begin
                  cur_col = COLUMNS - 1;
                  cur_row--;
               end
            end else begin
               cur_col--;
            end
         end
         KIND_CLEAR: begin
            blank_screen();
            clear_count++;
         end
         KIND_READ: begin
            rc = (item.read_col > COLUMNS - 1) ? COLUMNS - 1 : int'(item.read_col);
            rr = (item.read_row > ROWS - 1) ? ROWS - 1 : int'(item.read_row);
            want.cell_char = screen_cells[cell_index(rc, rr)];
            read_count++;
         end
         default: begin
         end
      endcase
      want.cursor_col = COL_W'(cur_col);
      want.cursor_row = ROW_W'(cur_row);
      return want;
   endfunction

   function automatic req_type random_item(input logic [2:0] kind);
      logic [63:0] bits;
      req_type     item;
      bits      = {$urandom, $urandom};
      item      = bits[$bits(req_type)-1:0];
      item.kind = kind;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      if (!no_gaps && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(console_step(item));
      sent_count++;
   endtask

   task automatic send_put(input logic [7:0] code);
      req_type item;
      item           = random_item(KIND_PUT);
      item.char_code = code;
      send_item(item);
   endtask

   task automatic send_set(input logic signed [7:0] col, input logic signed [7:0] row);
      req_type item;
      item            = random_item(KIND_SET);
      item.target_col = col;
      item.target_row = row;
      send_item(item);
   endtask

   task automatic send_read(input logic [4:0] col, input logic [4:0] row);
      req_type item;
      item          = random_item(KIND_READ);
      item.read_col = col;
      item.read_row = row;
      send_item(item);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_error("result with no transaction outstanding");
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (want.did_scroll) scroll_count++;
            if (rsp_item.cursor_col !== want.cursor_col) begin
               report_error($sformatf("cursor_col got %0d want %0d",
                                      rsp_item.cursor_col, want.cursor_col));
            end
            if (rsp_item.cursor_row !== want.cursor_row) begin
               report_error($sformatf("cursor_row got %0d want %0d",
                                      rsp_item.cursor_row, want.cursor_row));
            end
            if (rsp_item.cell_char !== want.cell_char) begin
               report_error($sformatf("cell_char got %0h want %0h",
                                      rsp_item.cell_char, want.cell_char));
            end
            if (rsp_item.did_scroll !== want.did_scroll) begin
               report_error($sformatf("did_scroll got %0b want %0b",
                                      rsp_item.did_scroll, want.did_scroll));
            end
         end
      end
   end

   task automatic test_idle_screen();
      send_read(5'd0, 5'd0);
      send_read(5'd31, 5'd31);
   endtask

   task automatic test_cursor_limits();
      send_set(-128, -128);
      send_set(127, 127);
      send_set(-1, 24);
   endtask

   task automatic test_wrap_and_scroll();
      send_set(31, 23);
      send_put(8'd255);
      send_read(5'd31, 5'd22);
      send_set(5, 23);
      send_put(CODE_LF);
   endtask

   task automatic test_control_codes();
      send_set(7, 3);
      send_put(CODE_NONE);
      send_put(CODE_CR);
      send_put(8'd1);
      send_put(CODE_LF);
   endtask

   task automatic test_step_back();
      send_set(0, 0);
      send_item(random_item(KIND_BACK));
      send_set(0, 5);
      send_item(random_item(KIND_BACK));
      send_item(random_item(KIND_BACK));
   endtask

   task automatic test_clear_screen();
      send_item(random_item(KIND_CLEAR));
      send_read(5'd31, 5'd22);
   endtask

   task automatic test_spare_kinds();
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
         send_item(random_item(3'(k)));
      end
   endtask

   task automatic test_random_text();
      int      pick;
      int      code;
      req_type item;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = (n >= CALM_FIRST && n < CALM_LAST);
         pick    = $urandom_range(0, 99);
         if (pick < 55) begin
            item = random_item(KIND_PUT);
            code = $urandom_range(0, 99);
            if (code < 70) begin
               item.char_code = 8'($urandom_range(32, 126));
            end else if (code < 80) begin
               item.char_code = CODE_CR;
            end else if (code < 92) begin
               item.char_code = CODE_LF;
            end else if (code < 95) begin
               item.char_code = CODE_NONE;
            end
         end else if (pick < 67) begin
            item = random_item(KIND_SET);
            if ($urandom_range(0, 9) < 7) begin
               item.target_col = 8'($urandom_range(0, COLUMNS - 1));
               if ($urandom_range(0, 1) == 0) begin
                  item.target_row = 8'(ROWS - 1 - $urandom_range(0, 2));
               end else begin
                  item.target_row = 8'($urandom_range(0, ROWS - 1));
               end
            end
         end else if (pick < 77) begin
            item = random_item(KIND_BACK);
         end else if (pick < 92) begin
            item = random_item(KIND_READ);
         end else if (pick < 97) begin
            item = random_item(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
         end else if (pick < 99) begin
            item           = random_item(KIND_PUT);
            item.char_code = CODE_LF;
         end else begin
            item = random_item(KIND_CLEAR);
         end
         send_item(item);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_rsp.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      blank_screen();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_screen();
      test_cursor_limits();
      test_wrap_and_scroll();
      test_control_codes();
      test_step_back();
      test_clear_screen();
      test_spare_kinds();
      test_random_text();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("tb: %0d transactions sent, %0d results checked, %0d errors",
               sent_count, checked_count, error_count);
      $display("tb: covered %0d scrolls, %0d cell reads, %0d screen clears in %0d cycles",
               scroll_count, read_count, clear_count, cycle_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
